// ===== hw/rtl/pebrf_pkg.sv =====
// Shared types and constants for the PE base-relocation fixup core.
// No dependencies; every other file takes names from here by scope.
package pebrf_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;

  // Register index as decoded from address bit 3 (registers at 8-byte spacing).
  localparam logic REG_BASE_DELTA        = 1'b0;
  localparam logic REG_FINAL_OFFSET_MASK = 1'b1;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  localparam logic [1:0] WS_NONE = 2'd0;
  localparam logic [1:0] WS_16   = 2'd1;
  localparam logic [1:0] WS_32   = 2'd2;
  localparam logic [1:0] WS_64   = 2'd3;

  localparam logic [31:0] JMP_MASK     = 32'h03ff_ffff;
  localparam logic [31:0] HIGHADJ_ROUND = 32'h0000_8000;

  typedef enum logic [3:0] {
    RT_ABSOLUTE     = 4'd0,
    RT_HIGH         = 4'd1,
    RT_LOW          = 4'd2,
    RT_HIGHLOW      = 4'd3,
    RT_HIGHADJ      = 4'd4,
    RT_MIPS_JMPADDR = 4'd5,
    RT_SECTION      = 4'd6,
    RT_REL32        = 4'd7,
    RT_IA64_IMM64   = 4'd9,
    RT_DIR64        = 4'd10
  } reloc_type_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] page_rva;
    logic [15:0] entry_code;
    logic [63:0] target_word;
  } in_item_t;

  typedef struct packed {
    logic [32:0] patch_addr;
    logic [63:0] patched_word;
    logic [1:0]  write_size;
    logic        bad_type;
  } out_item_t;

  typedef struct packed {
    logic signed [63:0] base_delta;
    logic [11:0]        final_offset_mask;
  } cfg_t;

  typedef struct packed {
    logic [31:0] page_base;
    logic        highadj_pending;
    logic        highadj_skip;
    logic [32:0] pending_addr;
    logic [15:0] pending_high_half;
  } fix_state_t;

endpackage

// ===== hw/rtl/pebrf_cfg.sv =====
// APB-style register file holding base_delta and final_offset_mask.
// Depends on pebrf_pkg for the address map and the register struct.
module pebrf_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pebrf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pebrf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pebrf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                              pready,
  output pebrf_pkg::cfg_t                   cfg
);

  logic [63:0] base_delta_r;
  logic [11:0] final_offset_mask_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_delta_r        <= '0;
      final_offset_mask_r <= '0;
    end else if (wr_en) begin
      unique case (paddr[3])
        pebrf_pkg::REG_BASE_DELTA:        base_delta_r        <= pwdata;
        pebrf_pkg::REG_FINAL_OFFSET_MASK: final_offset_mask_r <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      pebrf_pkg::REG_BASE_DELTA:        prdata = base_delta_r;
      pebrf_pkg::REG_FINAL_OFFSET_MASK: prdata = {52'd0, final_offset_mask_r};
      default:                          prdata = '0;
    endcase
  end

  assign cfg.base_delta        = base_delta_r;
  assign cfg.final_offset_mask = final_offset_mask_r;

endmodule

// ===== hw/rtl/pebrf_fixup.sv =====
// Single-pass fixup logic: decodes one item, forms the patched word and the next state.
// Depends on pebrf_pkg for item, register and state types.
module pebrf_fixup (
  input  pebrf_pkg::in_item_t   item,
  input  pebrf_pkg::fix_state_t st,
  input  pebrf_pkg::cfg_t       cfg,
  output logic                  emit,
  output pebrf_pkg::out_item_t  res,
  output pebrf_pkg::fix_state_t st_nxt
);

  logic [11:0]            offset;
  pebrf_pkg::reloc_type_t rtype;
  logic [32:0]            addr;
  logic [31:0]            w32;
  logic [31:0]            d32;
  logic [31:0]            t_high;
  logic [31:0]            t_low;
  logic [31:0]            t_jmp;
  logic [31:0]            t_adj;
  logic [63:0]            sum64;

  assign offset = item.entry_code[11:0];
  assign rtype  = pebrf_pkg::reloc_type_t'(item.entry_code[15:12]);
  assign addr   = {1'b0, st.page_base} + {21'd0, offset};
  assign w32    = item.target_word[31:0];
  assign d32    = cfg.base_delta[31:0];
  assign t_high = {w32[15:0], 16'd0} + d32;
  assign t_low  = {16'd0, w32[15:0]} + d32;
  assign t_jmp  = ((w32 & pebrf_pkg::JMP_MASK) << 2) + d32;
  assign t_adj  = {st.pending_high_half, 16'd0} + {{16{item.entry_code[15]}}, item.entry_code}
                  + d32 + pebrf_pkg::HIGHADJ_ROUND;
  assign sum64  = item.target_word + cfg.base_delta;

  always_comb begin
    st_nxt           = st;
    emit             = 1'b0;
    res.patch_addr   = addr;
    res.patched_word = '0;
    res.write_size   = pebrf_pkg::WS_NONE;
    res.bad_type     = 1'b0;
    if (item.kind == pebrf_pkg::KIND_HEADER) begin
      st_nxt.page_base       = item.page_rva;
      st_nxt.highadj_pending = 1'b0;
      st_nxt.highadj_skip    = 1'b0;
    end else if (st.highadj_pending) begin
      // This entry is the signed low half of the preceding HIGHADJ.
      st_nxt.highadj_pending = 1'b0;
      st_nxt.highadj_skip    = 1'b0;
      emit                   = !st.highadj_skip;
      res.patch_addr         = st.pending_addr;
      res.patched_word       = {48'd0, t_adj[31:16]};
      res.write_size         = pebrf_pkg::WS_16;
    end else begin
      unique case (rtype)
        pebrf_pkg::RT_ABSOLUTE,
        pebrf_pkg::RT_SECTION,
        pebrf_pkg::RT_REL32: emit = 1'b0;
        pebrf_pkg::RT_HIGH: begin
          emit             = 1'b1;
          res.patched_word = {48'd0, t_high[31:16]};
          res.write_size   = pebrf_pkg::WS_16;
        end
        pebrf_pkg::RT_LOW: begin
          emit             = 1'b1;
          res.patched_word = {48'd0, t_low[15:0]};
          res.write_size   = pebrf_pkg::WS_16;
        end
        pebrf_pkg::RT_HIGHLOW: begin
          emit             = 1'b1;
          res.patched_word = {32'd0, w32 + d32};
          res.write_size   = pebrf_pkg::WS_32;
        end
        pebrf_pkg::RT_HIGHADJ: begin
          st_nxt.highadj_pending   = 1'b1;
          st_nxt.highadj_skip      = |(offset & cfg.final_offset_mask);
          st_nxt.pending_addr      = addr;
          st_nxt.pending_high_half = w32[15:0];
        end
        pebrf_pkg::RT_MIPS_JMPADDR: begin
          emit             = 1'b1;
          res.patched_word = {32'd0, w32[31:26], t_jmp[27:2]};
          res.write_size   = pebrf_pkg::WS_32;
        end
        pebrf_pkg::RT_DIR64: begin
          emit             = 1'b1;
          res.patched_word = sum64;
          res.write_size   = pebrf_pkg::WS_64;
        end
        default: begin
          emit         = 1'b1;
          res.bad_type = 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/pe_base_relocation_fixup_core.sv =====
// Top level of the PE base-relocation fixup core: input register, fixup logic, result register.
// Depends on pebrf_pkg, pebrf_cfg and pebrf_fixup.
//
//   Channel   Direction  Handshake                         Payload
//   in_       in         in_valid / in_stall               pebrf_pkg::in_item_t
//   out_      out        out_valid / out_stall             pebrf_pkg::out_item_t
//   APB       in/out     psel, penable, pwrite, pready     paddr, pwdata, prdata
//
// One item is accepted per cycle while in_stall is low; the combinational fixup logic forms
// each result from the input register, and it is valid once loaded into the result register.
// While a result waits, the input register takes a new item unless the item it holds emits.
// Reset is synchronous, active low; it clears valid flags, page state and config registers.
// A stalled result holds the result register, and the input register fills behind it.
module pe_base_relocation_fixup_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pebrf_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pebrf_pkg::out_item_t              out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pebrf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pebrf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pebrf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                              pready
);

  pebrf_pkg::cfg_t       cfg;
  logic                  in_valid_r;
  pebrf_pkg::in_item_t   in_data_r;
  pebrf_pkg::fix_state_t st_r;
  pebrf_pkg::fix_state_t st_nxt;
  logic                  out_valid_r;
  pebrf_pkg::out_item_t  out_data_r;
  logic                  emit;
  pebrf_pkg::out_item_t  res;
  logic                  out_free;
  logic                  go;

  pebrf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pebrf_fixup u_fixup (
    .item   (in_data_r),
    .st     (st_r),
    .cfg    (cfg),
    .emit   (emit),
    .res    (res),
    .st_nxt (st_nxt)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign go       = in_valid_r && (!emit || out_free);
  assign in_stall = in_valid_r && !go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (go) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/pebrf_checker.sv =====
// Port-level checks for the PE base-relocation fixup core, bound to the top level.
// Depends on pebrf_pkg and pe_base_relocation_fixup_core.
module pebrf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input pebrf_pkg::out_item_t              out_data
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_bad_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_type |->
      out_data.write_size == pebrf_pkg::WS_NONE && out_data.patched_word == '0)
    else $error("bad type carries data");

  a_size16_zero_ext: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.write_size == pebrf_pkg::WS_16 |->
      out_data.patched_word[63:16] == '0 && !out_data.bad_type)
    else $error("16-bit result not zero extended");

  a_size32_zero_ext: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.write_size == pebrf_pkg::WS_32 |->
      out_data.patched_word[63:32] == '0 && !out_data.bad_type)
    else $error("32-bit result not zero extended");

endmodule

bind pe_base_relocation_fixup_core pebrf_checker u_pebrf_checker (.*);

// ===== dv/pe_base_relocation_fixup_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for pe_base_relocation_fixup_core: header and entry items are driven
// through the valid/stall channel; results are checked against an in-bench model or fixed rows.
// Depends on pebrf_pkg and the core RTL only.
module pe_base_relocation_fixup_core_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 310;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 6;

  // Entry types with no name in the package; all of them are rejected by the core.
  localparam logic [3:0] RT_GAP          = 4'd8;
  localparam logic [3:0] RT_BEYOND_DIR64 = 4'd11;
  localparam logic [3:0] RT_TOP          = 4'd15;

  typedef struct {
    pebrf_pkg::in_item_t  item;
    bit                   typed;
    bit                   gives;
    pebrf_pkg::out_item_t res;
  } reloc_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pebrf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pebrf_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [pebrf_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [pebrf_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [pebrf_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  // Model state and register copies.
  logic [63:0] delta = '0;
  logic [11:0] fmask = '0;
  logic [31:0] pg_base = '0;
  bit          adj_waiting = 1'b0;
  bit          adj_drop = 1'b0;
  logic [32:0] adj_addr = '0;
  logic [15:0] adj_hi = '0;

  pebrf_pkg::out_item_t fixups_due[$];
  pebrf_pkg::out_item_t want;
  reloc_row_t directed[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;

  pe_base_relocation_fixup_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic flag(input string what, input logic [63:0] got, input logic [63:0] exp_v);
    errors++;
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, exp_v);
  endtask

  // Outputs are stable at the falling edge, so a result seen here is taken at the next rise.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (fixups_due.size() == 0) begin
        flag("unexpected result, patch_addr", 64'(out_data.patch_addr), '0);
      end else begin
        want = fixups_due.pop_front();
        if (out_data.patch_addr !== want.patch_addr)
          flag("patch_addr", 64'(out_data.patch_addr), 64'(want.patch_addr));
        if (out_data.patched_word !== want.patched_word)
          flag("patched_word", out_data.patched_word, want.patched_word);
        if (out_data.write_size !== want.write_size)
          flag("write_size", 64'(out_data.write_size), 64'(want.write_size));
        if (out_data.bad_type !== want.bad_type)
          flag("bad_type", 64'(out_data.bad_type), 64'(want.bad_type));
      end
    end
  end

  function automatic bit fixup_predict(input pebrf_pkg::in_item_t it,
                                       output pebrf_pkg::out_item_t r);
    logic [11:0] ofs;
    logic [3:0]  rtype;
    logic [32:0] at;
    logic [31:0] w;
    logic [31:0] d;
    logic [31:0] t;
    ofs = it.entry_code[11:0];
    rtype = it.entry_code[15:12];
    at = {1'b0, pg_base} + {21'b0, ofs};
    w = it.target_word[31:0];
    d = delta[31:0];
    r = '0;
    if (it.kind == pebrf_pkg::KIND_HEADER) begin
      pg_base = it.page_rva;
      adj_waiting = 1'b0;
      adj_drop = 1'b0;
      return 1'b0;
    end
    if (adj_waiting) begin
      adj_waiting = 1'b0;
      if (adj_drop) begin
        adj_drop = 1'b0;
        return 1'b0;
      end
      t = {adj_hi, 16'h0000} + {{16{it.entry_code[15]}}, it.entry_code} + d
          + pebrf_pkg::HIGHADJ_ROUND;
      r.patch_addr = adj_addr;
      r.patched_word = {48'h0, t[31:16]};
      r.write_size = pebrf_pkg::WS_16;
      return 1'b1;
    end
    r.patch_addr = at;
    case (rtype)
      pebrf_pkg::RT_ABSOLUTE, pebrf_pkg::RT_SECTION, pebrf_pkg::RT_REL32: begin
        return 1'b0;
      end
      pebrf_pkg::RT_HIGH: begin
        t = {w[15:0], 16'h0000} + d;
        r.patched_word = {48'h0, t[31:16]};
        r.write_size = pebrf_pkg::WS_16;
      end
      pebrf_pkg::RT_LOW: begin
        t = {16'h0000, w[15:0]} + d;
        r.patched_word = {48'h0, t[15:0]};
        r.write_size = pebrf_pkg::WS_16;
      end
      pebrf_pkg::RT_HIGHLOW: begin
        r.patched_word = {32'h0, w + d};
        r.write_size = pebrf_pkg::WS_32;
      end
      pebrf_pkg::RT_HIGHADJ: begin
        adj_waiting = 1'b1;
        adj_drop = |(ofs & fmask);
        adj_addr = at;
        adj_hi = w[15:0];
        return 1'b0;
      end
      pebrf_pkg::RT_MIPS_JMPADDR: begin
        t = ((w & pebrf_pkg::JMP_MASK) << 2) + d;
        r.patched_word = {32'h0, (w & ~pebrf_pkg::JMP_MASK) | ((t >> 2) & pebrf_pkg::JMP_MASK)};
        r.write_size = pebrf_pkg::WS_32;
      end
      pebrf_pkg::RT_DIR64: begin
        r.patched_word = it.target_word + delta;
        r.write_size = pebrf_pkg::WS_64;
      end
      default: begin
        r.write_size = pebrf_pkg::WS_NONE;
        r.bad_type = 1'b1;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic pebrf_pkg::in_item_t hdr(input logic [31:0] page);
    pebrf_pkg::in_item_t it;
    it = '0;
    it.kind = pebrf_pkg::KIND_HEADER;
    it.page_rva = page;
    return it;
  endfunction

  function automatic pebrf_pkg::in_item_t entry(input logic [3:0] rt, input logic [11:0] ofs,
                                                input logic [63:0] w);
    pebrf_pkg::in_item_t it;
    it.kind = pebrf_pkg::KIND_ENTRY;
    it.page_rva = $urandom;
    it.entry_code = {rt, ofs};
    it.target_word = w;
    return it;
  endfunction

  function automatic pebrf_pkg::out_item_t bad_at(input logic [32:0] a);
    pebrf_pkg::out_item_t r;
    r.patch_addr = a;
    r.patched_word = '0;
    r.write_size = pebrf_pkg::WS_NONE;
    r.bad_type = 1'b1;
    return r;
  endfunction

  function automatic reloc_row_t reloc_row(input pebrf_pkg::in_item_t it, input bit typed,
                                           input bit gives, input pebrf_pkg::out_item_t r);
    reloc_row_t rw;
    rw.item = it;
    rw.typed = typed;
    rw.gives = gives;
    rw.res = r;
    return rw;
  endfunction

  function automatic pebrf_pkg::in_item_t random_item();
    pebrf_pkg::in_item_t it;
    int pick;
    pebrf_pkg::reloc_type_t rt;
    it.kind = pebrf_pkg::KIND_ENTRY;
    it.page_rva = $urandom;
    it.entry_code = 16'($urandom_range(16'hFFFF));
    it.target_word = {$urandom, $urandom};
    rt = pebrf_pkg::RT_ABSOLUTE;
    pick = $urandom_range(99);
    if (pick < 7) begin
      it.kind = pebrf_pkg::KIND_HEADER;
      if (pick < 2) it.page_rva = 32'hFFFF_F000 | $urandom_range(12'hFFF);
    end else if (pick >= 12) begin
      case ($urandom_range(9))
        0: rt = pebrf_pkg::RT_ABSOLUTE;
        1: rt = pebrf_pkg::RT_HIGH;
        2: rt = pebrf_pkg::RT_LOW;
        3: rt = pebrf_pkg::RT_HIGHLOW;
        4, 5: rt = pebrf_pkg::RT_HIGHADJ;
        6: rt = pebrf_pkg::RT_MIPS_JMPADDR;
        7: rt = pebrf_pkg::RT_DIR64;
        8: rt = pebrf_pkg::RT_SECTION;
        default: rt = pebrf_pkg::RT_REL32;
      endcase
      it.entry_code[15:12] = rt;
    end
    case ($urandom_range(19))
      0: it.target_word = '1;
      1: it.target_word = '0;
      2: it.entry_code[11:0] = '1;
      3: it.entry_code[11:0] = '0;
      default: ;
    endcase
    return it;
  endfunction

  task automatic write_reg(input logic idx, input logic [63:0] value);
    bit ready;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    ready = 1'b0;
    while (!ready) begin
      @(negedge clk);
      ready = pready;
      @(posedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == pebrf_pkg::REG_BASE_DELTA) delta = value;
    else fmask = value[11:0];
    @(posedge clk);
  endtask

  task automatic offer(input reloc_row_t rw);
    bit taken;
    bit has;
    pebrf_pkg::out_item_t p;
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rw.item;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    has = fixup_predict(rw.item, p);
    if (rw.typed) begin
      has = rw.gives;
      p = rw.res;
    end
    if (has) fixups_due.push_back(p);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (fixups_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input logic [63:0] d, input logic [11:0] m, input int s_pct,
                              input int r_pct, input bit with_hold, input bit with_pause);
    reloc_row_t rw;
    write_reg(pebrf_pkg::REG_BASE_DELTA, d);
    write_reg(pebrf_pkg::REG_FINAL_OFFSET_MASK, {52'h0, m});
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    rw.typed = 1'b0;
    rw.gives = 1'b0;
    rw.res = '0;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (k == PHASE_ITEMS / 2 && with_hold) holds_asked++;
      if (k == PHASE_ITEMS / 2 && with_pause) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (fixups_due.size() != 0);
      end
      rw.item = random_item();
      offer(rw);
    end
    settle();
  endtask

  initial begin
    directed.push_back(reloc_row(hdr(32'h0), 1'b1, 1'b0, '0));
    directed.push_back(reloc_row(entry(RT_GAP, 12'h000, '0), 1'b1, 1'b1, bad_at(33'h0)));
    directed.push_back(reloc_row(hdr(32'hFFFF_FFFF), 1'b1, 1'b0, '0));
    directed.push_back(reloc_row(entry(RT_TOP, 12'hFFF, '1), 1'b1, 1'b1,
                                 bad_at(33'h1_0000_0FFE)));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_IA64_IMM64, 12'h123,
                                       64'h0123_4567_89AB_CDEF),
                                 1'b1, 1'b1, bad_at(33'h1_0000_0122)));
    directed.push_back(reloc_row(entry(RT_BEYOND_DIR64, 12'h000, '1), 1'b1, 1'b1,
                                 bad_at(33'h0_FFFF_FFFF)));
    directed.push_back(reloc_row(hdr(32'h0040_1000), 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_ABSOLUTE, 12'h000, '1), 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_HIGH, 12'hFFF, '1), 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_LOW, 12'h001, 64'hFFFF), 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_HIGHLOW, 12'h7FF, 64'hFFFF_FFFF),
                                 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_MIPS_JMPADDR, 12'h010,
                                       64'h0123_4567_FFFF_FFFF),
                                 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_SECTION, 12'h004, '1), 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_REL32, 12'h008, '1), 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_DIR64, 12'h008, '1), 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_DIR64, 12'h010, '0), 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_HIGHADJ, 12'h020, 64'h1234),
                                 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(RT_GAP, 12'h000, '1), 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_HIGHADJ, 12'h024, 64'hFFFF),
                                 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_REL32, 12'hFFF, '0), 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_HIGHADJ, 12'h030, 64'h8000),
                                 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(hdr(32'h0000_2000), 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_HIGHLOW, 12'h004, 64'h7FFF_FFFF),
                                 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_HIGHADJ, 12'h800, 64'hABCD),
                                 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_HIGH, 12'h002, '1), 1'b0, 1'b0, '0));
    directed.push_back(reloc_row(entry(pebrf_pkg::RT_LOW, 12'h002, 64'h8001), 1'b0, 1'b0, '0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(pebrf_pkg::REG_BASE_DELTA, 64'hFFFF_FFFF_FFFF_8000);
    write_reg(pebrf_pkg::REG_FINAL_OFFSET_MASK, 64'h800);
    send_idle_pct = 13;
    recv_idle_pct = 56;
    foreach (directed[i]) offer(directed[i]);
    settle();

    random_phase('0, '0, 13, 56, 1'b0, 1'b0);
    random_phase(64'h7FFF_FFFF_FFFF_FFFF, 12'hFFF, 13, 56, 1'b1, 1'b0);
    random_phase(64'h8000_0000_0000_0000, 12'($urandom_range(12'hFFF)), 56, 13, 1'b0, 1'b1);
    random_phase({$urandom, $urandom}, 12'($urandom_range(12'hFFF)), 56, 13, 1'b0, 1'b0);
    random_phase({$urandom, $urandom}, 12'($urandom_range(12'hFFF)), 0, 0, 1'b0, 1'b0);
    random_phase({$urandom, $urandom}, 12'($urandom_range(12'hFFF)), 0, 0, 1'b0, 1'b0);

    if (fixups_due.size() != 0) flag("results never arrived", 64'(fixups_due.size()), '0);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pebrf_pkg.sv
hw/rtl/pebrf_cfg.sv
hw/rtl/pebrf_fixup.sv
hw/rtl/pe_base_relocation_fixup_core.sv
hw/rtl/pebrf_checker.sv
dv/pe_base_relocation_fixup_core_tb.sv
